/* rtl/core/spda_pkg.sv */
// Shared types and constants for the sensor poll / DAC arbiter core.
package spda_pkg;

  // Field widths
  localparam int unsigned CodeW   = 12;
  localparam int unsigned CmdW    = 16;
  localparam int unsigned AvgW    = 20;
  localparam int unsigned RatioW  = 15;
  localparam int unsigned AlphaW  = 8;
  localparam int unsigned GainW   = 16;
  localparam int unsigned OffsW   = 13;
  localparam int unsigned CorrW   = 13;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // Serial multiplier: partial product register and step counter
  localparam int unsigned PartW = AvgW + 1;
  localparam int unsigned CntW  = 4;

  // Command word
  localparam logic [CmdW-1:0] CmdWriteBit  = 16'h8000;
  localparam logic [2:0]      CmdChanBaseA = 3'd4;
  localparam logic [2:0]      CmdChanBaseB = 3'd5;

  localparam logic [RatioW-1:0] FakeRatio = 15'd3200;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgFakeMode  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRatioCorr = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAlpha     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLowLimit  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgHighLimit = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRatioOffs = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgRatioGain = 3'd6;

  // Register reset values
  localparam logic [CorrW-1:0]  RstRatioCorr = 13'd0;
  localparam logic [AlphaW-1:0] RstAlpha     = 8'd51;
  localparam logic [CodeW-1:0]  RstLowLimit  = 12'd410;
  localparam logic [CodeW-1:0]  RstHighLimit = 12'd3686;
  localparam logic [OffsW-1:0]  RstRatioOffs = 13'd1872;
  localparam logic [GainW-1:0]  RstRatioGain = 16'd48640;

  // Rounding constant for the average: 0.5 in Q12.8
  localparam logic [PartW-1:0] AvgRound = 21'd128;

  // Last step indexes of the two serial multiplies
  localparam logic [CntW-1:0] AvgLastStep  = 4'd8;   // 9 bits of 256-alpha
  localparam logic [CntW-1:0] GainLastStep = 4'd15;  // 16 bits of gain

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StAvg  = 4'b0010,
    StGain = 4'b0100,
    StFin  = 4'b1000
  } state_e;

endpackage

/* rtl/core/sensor_poll_dac_arbiter_core.sv */
// Sensor poll / DAC arbiter core: arbitration, serial EMA and ratio calculation.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, dac_*_i, adc_code_i    | in
//  out     | out_valid_o, out_stall_i, command_word_o, ...  | out
//  cfg     | cfg_we_i, cfg_index_i, cfg_wdata_i             | in
//
// A poll runs from transfer to result in the output register through the
// bit-serial average multiply (bits of 256-alpha), the bit-serial gain
// multiply, and a final step that forms the ratio and loads it.
// A new poll is taken only once the previous one has left the arithmetic unit.
// A stalled output holds the finished poll; the next result waits until it moves.
// Reset (rst_ni, async low) loads the register defaults and clears the state.
module sensor_poll_dac_arbiter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write port
  input  logic                                cfg_we_i,
  input  logic [spda_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [spda_pkg::CfgDatW-1:0]        cfg_wdata_i,
  // poll input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                dac_pending_a_i,
  input  logic                                dac_pending_b_i,
  input  logic [spda_pkg::CodeW-1:0]          dac_value_a_i,
  input  logic [spda_pkg::CodeW-1:0]          dac_value_b_i,
  input  logic [spda_pkg::CodeW-1:0]          adc_code_i,
  // poll result
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [spda_pkg::CmdW-1:0]           command_word_o,
  output logic                                served_a_o,
  output logic                                served_b_o,
  output logic [spda_pkg::AvgW-1:0]           smoothed_code_o,
  output logic signed [spda_pkg::RatioW-1:0]  ratio_value_o,
  output logic                                below_range_o,
  output logic                                sensor_fault_o
);

  // config registers
  logic                          fake_mode_q;
  logic [spda_pkg::CorrW-1:0]    ratio_corr_q;
  logic [spda_pkg::AlphaW-1:0]   alpha_q;
  logic [spda_pkg::CodeW-1:0]    low_limit_q;
  logic [spda_pkg::CodeW-1:0]    high_limit_q;
  logic [spda_pkg::OffsW-1:0]    ratio_offs_q;
  logic [spda_pkg::GainW-1:0]    ratio_gain_q;

  // state
  spda_pkg::state_e              state_q, state_d;
  logic                          next_ch_q, next_ch_d;
  logic [spda_pkg::AvgW-1:0]     avg_q, avg_d;
  logic [spda_pkg::CntW-1:0]     cnt_q, cnt_d;

  // per-poll work registers
  logic [spda_pkg::CodeW-1:0]    code_q, code_d;
  logic [spda_pkg::GainW-1:0]    mplr_q, mplr_d;   // alpha, then gain; LSB first
  logic [spda_pkg::AlphaW:0]     beta_q, beta_d;   // 256 - alpha; LSB first
  logic [spda_pkg::PartW-1:0]    part_q, part_d;
  logic [spda_pkg::CmdW-1:0]     cmd_q, cmd_d;
  logic                          srv_a_q, srv_a_d;
  logic                          srv_b_q, srv_b_d;
  logic                          nr_q, nr_d;
  logic                          flt_q, flt_d;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic [spda_pkg::CmdW-1:0]     out_cmd_q, out_cmd_d;
  logic                          out_srv_a_q, out_srv_a_d;
  logic                          out_srv_b_q, out_srv_b_d;
  logic [spda_pkg::AvgW-1:0]     out_avg_q, out_avg_d;
  logic [spda_pkg::RatioW-1:0]   out_ratio_q, out_ratio_d;
  logic                          out_nr_q, out_nr_d;
  logic                          out_flt_q, out_flt_d;

  logic                          in_xfer, out_free;
  logic                          arb_ch;
  logic [spda_pkg::AvgW:0]       addend;
  logic [spda_pkg::PartW:0]      psum;
  logic [spda_pkg::PartW:0]      term_sum;
  logic [15:0]                   ratio_sum;

  assign in_stall_o = (state_q != spda_pkg::StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // arbitration: a lone request redirects the pointer first
  always_comb begin
    arb_ch = next_ch_q;
    if (!dac_pending_a_i && dac_pending_b_i) begin
      arb_ch = 1'b1;
    end else if (dac_pending_a_i && !dac_pending_b_i) begin
      arb_ch = 1'b0;
    end
  end

  // one step of the serial-parallel multiplier; the average phase adds both terms
  always_comb begin
    addend = '0;
    if (state_q == spda_pkg::StAvg) begin
      addend = (mplr_q[0] ? {1'b0, code_q, 8'd0} : '0)
             + (beta_q[0] ? {1'b0, avg_q} : '0);
    end else begin
      addend = mplr_q[0] ? {1'b0, avg_q} : '0;
    end
    psum = {1'b0, part_q} + addend;
  end

  // (P + 128) >> 8 is the rounded high part of gain * average >> 24
  assign term_sum  = {1'b0, part_q} + {1'b0, spda_pkg::AvgRound};
  assign ratio_sum = {3'd0, ratio_offs_q}
                   + {2'd0, term_sum[spda_pkg::PartW:8]}
                   + {{3{ratio_corr_q[spda_pkg::CorrW-1]}}, ratio_corr_q};

  always_comb begin
    state_d   = state_q;
    next_ch_d = next_ch_q;
    avg_d     = avg_q;
    cnt_d     = cnt_q;
    code_d    = code_q;
    mplr_d    = mplr_q;
    beta_d    = beta_q;
    part_d    = part_q;
    cmd_d     = cmd_q;
    srv_a_d   = srv_a_q;
    srv_b_d   = srv_b_q;
    nr_d      = nr_q;
    flt_d     = flt_q;

    out_valid_d = out_valid_q && out_stall_i;
    out_cmd_d   = out_cmd_q;
    out_srv_a_d = out_srv_a_q;
    out_srv_b_d = out_srv_b_q;
    out_avg_d   = out_avg_q;
    out_ratio_d = out_ratio_q;
    out_nr_d    = out_nr_q;
    out_flt_d   = out_flt_q;

    unique case (state_q)
      spda_pkg::StIdle: begin
        if (in_xfer) begin
          code_d  = adc_code_i;
          mplr_d  = {{(spda_pkg::GainW-spda_pkg::AlphaW){1'b0}}, alpha_q};
          beta_d  = 9'd256 - {1'b0, alpha_q};
          part_d  = spda_pkg::AvgRound;
          cnt_d   = '0;
          nr_d    = adc_code_i < low_limit_q;
          flt_d   = adc_code_i > high_limit_q;
          srv_a_d = 1'b0;
          srv_b_d = 1'b0;
          cmd_d   = '0;
          next_ch_d = arb_ch;
          if (!arb_ch && dac_pending_a_i) begin
            srv_a_d   = 1'b1;
            cmd_d     = spda_pkg::CmdWriteBit | {1'b0, spda_pkg::CmdChanBaseA, dac_value_a_i};
            next_ch_d = 1'b1;
          end else if (arb_ch && dac_pending_b_i) begin
            srv_b_d   = 1'b1;
            cmd_d     = spda_pkg::CmdWriteBit | {1'b0, spda_pkg::CmdChanBaseB, dac_value_b_i};
            next_ch_d = 1'b0;
          end
          state_d = spda_pkg::StAvg;
        end
      end
      spda_pkg::StAvg: begin
        part_d = psum[spda_pkg::PartW:1];
        mplr_d = mplr_q >> 1;
        beta_d = beta_q >> 1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == spda_pkg::AvgLastStep) begin
          // high product bits plus the last bit shifted out: acc >> 8
          avg_d   = psum[spda_pkg::AvgW-1:0];
          mplr_d  = ratio_gain_q;
          part_d  = '0;
          cnt_d   = '0;
          state_d = spda_pkg::StGain;
        end
      end
      spda_pkg::StGain: begin
        part_d = psum[spda_pkg::PartW:1];
        mplr_d = mplr_q >> 1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == spda_pkg::GainLastStep) begin
          state_d = spda_pkg::StFin;
        end
      end
      spda_pkg::StFin: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_cmd_d   = cmd_q;
          out_srv_a_d = srv_a_q;
          out_srv_b_d = srv_b_q;
          out_avg_d   = avg_q;
          if (fake_mode_q) begin
            out_ratio_d = spda_pkg::FakeRatio;
            out_nr_d    = 1'b0;
            out_flt_d   = 1'b0;
          end else begin
            out_ratio_d = (nr_q || flt_q) ? '0 : ratio_sum[spda_pkg::RatioW-1:0];
            out_nr_d    = nr_q;
            out_flt_d   = flt_q;
          end
          state_d = spda_pkg::StIdle;
        end
      end
      default: state_d = spda_pkg::StIdle;
    endcase
  end

  // config writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fake_mode_q  <= 1'b0;
      ratio_corr_q <= spda_pkg::RstRatioCorr;
      alpha_q      <= spda_pkg::RstAlpha;
      low_limit_q  <= spda_pkg::RstLowLimit;
      high_limit_q <= spda_pkg::RstHighLimit;
      ratio_offs_q <= spda_pkg::RstRatioOffs;
      ratio_gain_q <= spda_pkg::RstRatioGain;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        spda_pkg::CfgFakeMode:  fake_mode_q  <= cfg_wdata_i[0];
        spda_pkg::CfgRatioCorr: ratio_corr_q <= cfg_wdata_i[spda_pkg::CorrW-1:0];
        spda_pkg::CfgAlpha:     alpha_q      <= cfg_wdata_i[spda_pkg::AlphaW-1:0];
        spda_pkg::CfgLowLimit:  low_limit_q  <= cfg_wdata_i[spda_pkg::CodeW-1:0];
        spda_pkg::CfgHighLimit: high_limit_q <= cfg_wdata_i[spda_pkg::CodeW-1:0];
        spda_pkg::CfgRatioOffs: ratio_offs_q <= cfg_wdata_i[spda_pkg::OffsW-1:0];
        spda_pkg::CfgRatioGain: ratio_gain_q <= cfg_wdata_i[spda_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spda_pkg::StIdle;
      next_ch_q   <= 1'b0;
      avg_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_ch_q   <= next_ch_d;
      avg_q       <= avg_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    code_q      <= code_d;
    mplr_q      <= mplr_d;
    beta_q      <= beta_d;
    part_q      <= part_d;
    cmd_q       <= cmd_d;
    srv_a_q     <= srv_a_d;
    srv_b_q     <= srv_b_d;
    nr_q        <= nr_d;
    flt_q       <= flt_d;
    out_cmd_q   <= out_cmd_d;
    out_srv_a_q <= out_srv_a_d;
    out_srv_b_q <= out_srv_b_d;
    out_avg_q   <= out_avg_d;
    out_ratio_q <= out_ratio_d;
    out_nr_q    <= out_nr_d;
    out_flt_q   <= out_flt_d;
  end

  assign out_valid_o     = out_valid_q;
  assign command_word_o  = out_cmd_q;
  assign served_a_o      = out_srv_a_q;
  assign served_b_o      = out_srv_b_q;
  assign smoothed_code_o = out_avg_q;
  assign ratio_value_o   = out_ratio_q;
  assign below_range_o   = out_nr_q;
  assign sensor_fault_o  = out_flt_q;

endmodule
